// ===== design/button_debounce_press_hold_defines.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef BUTTON_DEBOUNCE_PRESS_HOLD_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_HOLD_DEFINES_SVH

// clocked assertion, off while reset is held
`define BDPH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also runs across reset
`define BDPH_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/bdph_pkg.sv =====
// types and constants for the button debouncer with press and hold reporting
// no dependencies
`default_nettype none

package bdph_pkg;

    localparam int HOLD_W  = 16;
    localparam int PIN_W   = 3;
    localparam int IDX_W   = 2;
    localparam int MASK_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [HOLD_W-1:0] HOLD_PERIOD_RESET   = 16'd200;
    localparam logic              PRESSED_LEVEL_RESET = 1'b0;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_PERIOD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 1'd1;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_PRESS = 2'd1,
        REQ_HOLD  = 2'd2
    } req_type_t;

    typedef struct packed {
        logic tick;
        logic level;
        logic clr_press;
        logic clr_hold;
    } bdph_btn_ctrl_t;

    typedef struct packed {
        logic press_cur;
        logic hold_cur;
        logic press_next;
        logic hold_next;
    } bdph_btn_stat_t;

endpackage

`default_nettype wire

// ===== design/bdph_button.sv =====
// per-button state: sample history, stable level, hold counter, sticky flags
// depends on bdph_pkg
`default_nettype none

module bdph_button import bdph_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bdph_btn_ctrl_t    ctrl,
    input  wire logic [HOLD_W-1:0] hold_period,
    input  wire logic              pressed_level,
    output bdph_btn_stat_t         stat
);

    logic [1:0]        hist_reg, hist_next;
    logic              stable_reg, stable_next;
    logic [HOLD_W-1:0] cnt_reg, cnt_next;
    logic              press_reg, press_next;
    logic              hold_reg, hold_next;
    logic [HOLD_W-1:0] cnt_dec;

    assign cnt_dec = cnt_reg - {{(HOLD_W-1){1'b0}}, 1'b1};

    always_comb begin
        hist_next   = hist_reg;
        stable_next = stable_reg;
        cnt_next    = cnt_reg;
        press_next  = press_reg;
        hold_next   = hold_reg;
        if (ctrl.tick) begin
            hist_next = {hist_reg[0], ctrl.level};
            if (hist_reg[1] == hist_reg[0] && hist_reg[0] == ctrl.level) begin
                if (stable_reg != ctrl.level) begin
                    stable_next = ctrl.level;
                    if (ctrl.level == pressed_level) begin
                        press_next = 1'b1;
                        cnt_next   = hold_period;
                    end
                end else if (cnt_dec == '0) begin
                    if (ctrl.level == pressed_level) begin
                        hold_next = 1'b1;
                    end
                    cnt_next = hold_period;
                end else begin
                    cnt_next = cnt_dec;
                end
            end
        end
        if (ctrl.clr_press) begin
            press_next = 1'b0;
        end
        if (ctrl.clr_hold) begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg   <= {2{~PRESSED_LEVEL_RESET}};
            stable_reg <= ~PRESSED_LEVEL_RESET;
            cnt_reg    <= HOLD_PERIOD_RESET;
            press_reg  <= 1'b0;
            hold_reg   <= 1'b0;
        end else begin
            hist_reg   <= hist_next;
            stable_reg <= stable_next;
            cnt_reg    <= cnt_next;
            press_reg  <= press_next;
            hold_reg   <= hold_next;
        end
    end

    assign stat.press_cur  = press_reg;
    assign stat.hold_cur   = hold_reg;
    assign stat.press_next = press_next;
    assign stat.hold_next  = hold_next;

endmodule

`default_nettype wire

// ===== design/button_debounce_press_hold.sv =====
// Debouncer for NUM_BUTTONS buttons with sticky press and repeating hold flags.
// An item is taken in every cycle unless the output is stalled: it lands in an input
// register, the per-button update runs as the item leaves that register and the result
// register holds the answer. The per-button update of history, level, counter and flags
// sets that rate. Each item yields exactly one result item. Configuration writes take
// effect at once; a new hold period is used at the next counter reload.
// depends on bdph_pkg and bdph_button
`default_nettype none

module button_debounce_press_hold import bdph_pkg::*; #(
    parameter int NUM_BUTTONS = 3
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [7:0]           s_tdata,   // pin_levels[2:0], button_index[4:3]
    input  wire logic [1:0]           s_tuser,   // req_type[1:0]
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [7:0]           m_tdata,   // flag_value[0], press_pending[3:1],
                                                 // hold_pending[6:4]
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [HOLD_W-1:0]    cfg_data
);

    logic              in_v_reg;
    req_type_t         req_reg;
    logic [PIN_W-1:0]  pins_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              advance;

    logic [HOLD_W-1:0] period_reg;
    logic              plevel_reg;

    logic              out_v_reg;
    logic              flag_reg, flag_next;
    logic [MASK_W-1:0] pmask_reg, pmask_next;
    logic [MASK_W-1:0] hmask_reg, hmask_next;

    bdph_btn_ctrl_t    ctrl [NUM_BUTTONS];
    bdph_btn_stat_t    stat [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] sel;
    logic              press_sel, hold_sel;

    assign advance  = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready = !in_v_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= HOLD_PERIOD_RESET;
            plevel_reg <= PRESSED_LEVEL_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_HOLD_PERIOD:   period_reg <= cfg_data;
                CFG_PRESSED_LEVEL: plevel_reg <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tready) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            req_reg  <= req_type_t'(s_tuser[1:0]);
            pins_reg <= s_tdata[PIN_W-1:0];
            idx_reg  <= s_tdata[PIN_W+IDX_W-1:PIN_W];
        end
    end

    genvar b;
    generate
        for (b = 0; b < NUM_BUTTONS; b++) begin : g_btn
            assign sel[b] = (32'(idx_reg) == b);
            assign ctrl[b].tick      = advance && (req_reg == REQ_TICK);
            assign ctrl[b].clr_press = advance && (req_reg == REQ_PRESS) && sel[b];
            assign ctrl[b].clr_hold  = advance && (req_reg == REQ_HOLD) && sel[b];
            if (b < PIN_W) begin : g_pin
                assign ctrl[b].level = pins_reg[b];
            end else begin : g_nopin
                assign ctrl[b].level = 1'b0;
            end

            bdph_button u_btn (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .ctrl          (ctrl[b]),
                .hold_period   (period_reg),
                .pressed_level (plevel_reg),
                .stat          (stat[b])
            );
        end

        for (b = 0; b < MASK_W; b++) begin : g_mask
            if (b < NUM_BUTTONS) begin : g_on
                assign pmask_next[b] = stat[b].press_next;
                assign hmask_next[b] = stat[b].hold_next;
            end else begin : g_off
                assign pmask_next[b] = 1'b0;
                assign hmask_next[b] = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        press_sel = 1'b0;
        hold_sel  = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (sel[i]) begin
                press_sel = stat[i].press_cur;
                hold_sel  = stat[i].hold_cur;
            end
        end
    end

    always_comb begin
        unique case (req_reg)
            REQ_PRESS: flag_next = press_sel;
            REQ_HOLD:  flag_next = hold_sel;
            default:   flag_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (advance) begin
            out_v_reg <= 1'b1;
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            flag_reg  <= flag_next;
            pmask_reg <= pmask_next;
            hmask_reg <= hmask_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {1'b0, hmask_reg, pmask_reg, flag_reg};

endmodule

`default_nettype wire

// ===== design/bdph_checker.sv =====
// port-level checks for button_debounce_press_hold, bound to the top level
// depends on bdph_pkg and button_debounce_press_hold_defines.svh
`default_nettype none

`include "button_debounce_press_hold_defines.svh"

module bdph_checker import bdph_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [7:0]           s_tdata,
    input wire logic [1:0]           s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [7:0]           m_tdata,
    input wire logic                 cfg_we,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [HOLD_W-1:0]    cfg_data
);

    // a stalled result stays put
    `BDPH_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // input only backs up when the output side is stalled
    `BDPH_ASSERT(a_ready_backpressure, !s_tready |-> m_tvalid && !m_tready, "input stalled without output stall")

    // nothing is offered right after reset
    `BDPH_ASSERT_RST(a_reset_empty, $rose(aresetn) |-> !m_tvalid && s_tready, "pipeline not empty after reset")

endmodule

bind button_debounce_press_hold bdph_checker u_bdph_checker (.*);

`default_nettype wire
